### hdl/slc_pkg.sv
// Shared types and constants for the serial line checksum receiver.
// No dependencies; used by every module of the block.
`default_nettype none

package slc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 7;
  localparam int unsigned SumW   = 14;

  localparam logic [ByteW-1:0] CH_NEWLINE = 8'd10;
  localparam logic [ByteW-1:0] CH_SPACE   = 8'd32;
  localparam logic [ByteW-1:0] CH_STAR    = 8'd42;
  localparam logic [ByteW-1:0] CH_CARET   = 8'd94;
  localparam logic [ByteW-1:0] CH_QUERY   = 8'd63;

  localparam logic [SumW-1:0] SUM_WRAP    = 14'd128;
  localparam logic [SumW-1:0] CHK_OFFSET  = 14'd128;

  localparam logic [2:0] V_EXEC     = 3'd0;
  localparam logic [2:0] V_QUERY    = 3'd1;
  localparam logic [2:0] V_SKIP     = 3'd2;
  localparam logic [2:0] V_TXERR    = 3'd3;
  localparam logic [2:0] V_OVERFLOW = 3'd4;
  localparam logic [2:0] V_STOPPED  = 3'd5;

  localparam logic [1:0] START_PLAIN  = 2'd0;
  localparam logic [1:0] START_MARKED = 2'd2;

  typedef struct packed {
    logic [2:0]        verdict;
    logic [1:0]        payload_start;
    logic [CountW-1:0] line_length;
  } slc_res_t;

endpackage

`default_nettype wire

### hdl/serial_line_checksum_receiver.sv
// Serial line checksum receiver: takes one received byte per word, one word
// per cycle when the result side keeps up. Each byte is registered on entry in
// the input register; combinational logic then updates the line state and, at
// line end or overflow, loads the verdict into the output register, from which
// it appears on the output. A held result only stalls input once the input
// register is full too.
// Depends on slc_pkg, slc_line and slc_out_reg.
`default_nettype none

module serial_line_checksum_receiver #(
  parameter int unsigned LINE_CAPACITY = 80
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_machine_stopped,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_verdict,
  output logic [1:0]      out_payload_start,
  output logic [6:0]      out_line_length
);

  logic                      in_valid_r;
  logic [slc_pkg::ByteW-1:0] rx_r;
  logic                      stop_r;
  logic                      step;
  logic                      can_take;
  logic                      res_valid;
  slc_pkg::slc_res_t         res;
  slc_pkg::slc_res_t         res_out;

  assign step     = in_valid_r && can_take;
  assign in_ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rx_r   <= in_rx_byte;
      stop_r <= in_machine_stopped;
    end
  end

  slc_line #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_line (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .rx_byte        (rx_r),
    .machine_stopped(stop_r),
    .res_valid      (res_valid),
    .res            (res)
  );

  slc_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step && res_valid),
    .res_in   (res),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .res_out  (res_out),
    .can_take (can_take)
  );

  assign out_verdict       = res_out.verdict;
  assign out_payload_start = res_out.payload_start;
  assign out_line_length   = res_out.line_length;

  // a line never holds more than capacity-1 kept characters
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_line_length} <= 8'(LINE_CAPACITY - 1)))
    else $error("line length beyond capacity");

  a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_verdict == slc_pkg::V_OVERFLOW))
      |-> ({1'b0, out_line_length} == 8'(LINE_CAPACITY - 1)))
    else $error("overflow verdict with short line");

  // checksum verdicts only come from marked lines
  a_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_verdict == slc_pkg::V_SKIP) || (out_verdict == slc_pkg::V_TXERR)))
      |-> (out_payload_start == slc_pkg::START_MARKED))
    else $error("skip or error verdict on plain line");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid && !out_ready))
    else $error("input stalled without a held result");

endmodule

`default_nettype wire

### hdl/slc_line.sv
// Line assembly state, running checksum and per-line verdict logic.
// Depends on slc_pkg.
`default_nettype none

module slc_line #(
  parameter int unsigned LINE_CAPACITY = 80
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step,
  input  wire logic [slc_pkg::ByteW-1:0] rx_byte,
  input  wire logic                      machine_stopped,
  output logic                           res_valid,
  output slc_pkg::slc_res_t              res
);

  localparam logic [7:0] CAP = 8'(LINE_CAPACITY);

  logic [slc_pkg::CountW-1:0] cnt_r, cnt_nxt;
  logic [slc_pkg::ByteW-1:0]  marker_r, marker_nxt;
  logic [slc_pkg::ByteW-1:0]  chk_r, chk_nxt;
  logic [slc_pkg::ByteW-1:0]  first_r, first_nxt;
  logic [slc_pkg::SumW-1:0]   sum_r, sum_nxt;
  logic                       dup_r, dup_nxt;

  logic                       marked;
  logic                       byte_marked;
  logic                       ovf;
  logic [slc_pkg::SumW-1:0]   expect_sum;
  logic [slc_pkg::SumW-1:0]   sum_add;
  logic                       chk_match;
  logic [2:0]                 plain_v;
  logic [2:0]                 verdict;

  assign marked      = (marker_r == slc_pkg::CH_STAR) || (marker_r == slc_pkg::CH_CARET);
  assign byte_marked = (rx_byte == slc_pkg::CH_STAR) || (rx_byte == slc_pkg::CH_CARET);
  assign ovf         = ({1'b0, cnt_r} + 8'd1) >= CAP;
  assign expect_sum  = {1'b0, sum_r[slc_pkg::SumW-1:1]} + slc_pkg::CHK_OFFSET;
  assign chk_match   = expect_sum == {{(slc_pkg::SumW-slc_pkg::ByteW){1'b0}}, chk_r};
  assign plain_v     = (first_r == slc_pkg::CH_QUERY) ? slc_pkg::V_QUERY : slc_pkg::V_EXEC;
  assign sum_add     = sum_r + {{(slc_pkg::SumW-slc_pkg::ByteW){1'b0}}, rx_byte};

  always_comb begin
    cnt_nxt    = cnt_r;
    marker_nxt = marker_r;
    chk_nxt    = chk_r;
    first_nxt  = first_r;
    sum_nxt    = sum_r;
    dup_nxt    = dup_r;
    res_valid  = 1'b0;
    verdict    = slc_pkg::V_EXEC;

    if (ovf || (rx_byte == slc_pkg::CH_NEWLINE)) begin
      if (ovf) begin
        res_valid = 1'b1;
        verdict   = slc_pkg::V_OVERFLOW;
      end else if (cnt_r != '0) begin
        res_valid = 1'b1;
        if (machine_stopped) begin
          verdict = slc_pkg::V_STOPPED;
        end else if (!marked) begin
          verdict = plain_v;
        end else if (dup_r) begin
          verdict = slc_pkg::V_SKIP;
          if (marker_r == slc_pkg::CH_STAR) begin
            dup_nxt = 1'b0;
          end
        end else if (!chk_r[7]) begin
          verdict = slc_pkg::V_TXERR;
        end else if (!chk_match) begin
          verdict = (marker_r == slc_pkg::CH_CARET) ? slc_pkg::V_SKIP : slc_pkg::V_TXERR;
        end else begin
          verdict = plain_v;
          if (marker_r == slc_pkg::CH_CARET) begin
            dup_nxt = 1'b1;
          end
        end
      end
      // any verdict ends the line
      if (res_valid) begin
        cnt_nxt    = '0;
        marker_nxt = '0;
        chk_nxt    = '0;
        first_nxt  = '0;
        sum_nxt    = '0;
      end
    end else if (rx_byte > slc_pkg::CH_SPACE) begin
      if (cnt_r == 7'd0) begin
        marker_nxt = rx_byte;
        if (!byte_marked) begin
          first_nxt = rx_byte;
        end
      end else if (cnt_r == 7'd1) begin
        if (marked) begin
          chk_nxt = rx_byte;
        end
      end else begin
        if ((cnt_r == 7'd2) && marked) begin
          first_nxt = rx_byte;
        end
        sum_nxt = (sum_add >= slc_pkg::SUM_WRAP) ? (sum_add - slc_pkg::SUM_WRAP) : sum_add;
      end
      cnt_nxt = cnt_r + 7'd1;
    end
  end

  assign res.verdict       = verdict;
  assign res.payload_start = marked ? slc_pkg::START_MARKED : slc_pkg::START_PLAIN;
  assign res.line_length   = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      marker_r <= '0;
      chk_r    <= '0;
      first_r  <= '0;
      sum_r    <= '0;
      dup_r    <= 1'b0;
    end else if (step) begin
      cnt_r    <= cnt_nxt;
      marker_r <= marker_nxt;
      chk_r    <= chk_nxt;
      first_r  <= first_nxt;
      sum_r    <= sum_nxt;
      dup_r    <= dup_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/slc_out_reg.sv
// Result register for the verdict channel.
// Depends on slc_pkg.
`default_nettype none

module slc_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire slc_pkg::slc_res_t res_in,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output slc_pkg::slc_res_t      res_out,
  output logic                   can_take
);

  logic              valid_r;
  slc_pkg::slc_res_t res_r;

  assign can_take  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb_serial_line_checksum_receiver.sv
`timescale 1ns / 100ps
// Testbench for serial_line_checksum_receiver: a directed table, then random lines.
// Verdicts are checked against typed table rows or a line-state tracker in the bench.
// Depends on slc_pkg and the receiver RTL.

module tb_serial_line_checksum_receiver;

  localparam int unsigned LineCap    = 80;
  localparam int unsigned RandWords  = 850;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 200;

  typedef struct {
    logic [7:0]        rx;
    logic              stop;
    bit                typed;
    bit                fires;
    slc_pkg::slc_res_t res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'd0;
  logic       in_machine_stopped = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_verdict;
  logic [1:0] out_payload_start;
  logic [6:0] out_line_length;

  // line state as seen by the bench
  logic [6:0]  held_len;
  logic [7:0]  lead_char;
  logic [7:0]  sent_chk;
  logic [7:0]  cmd_char;
  logic [13:0] pay_sum;
  logic        copy_taken;

  slc_pkg::slc_res_t pending_verdicts[$];
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;
  bit                no_idle = 1'b0;
  dir_row_t          dir_tab[26];

  always #1 clk = ~clk;

  serial_line_checksum_receiver #(.LINE_CAPACITY(LineCap)) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .in_machine_stopped (in_machine_stopped),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict),
    .out_payload_start  (out_payload_start),
    .out_line_length    (out_line_length)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  task automatic clear_line();
    held_len  = '0;
    lead_char = '0;
    sent_chk  = '0;
    cmd_char  = '0;
    pay_sum   = '0;
  endtask

  // Advance the line state by one accepted word; fires when a verdict is due.
  task automatic track_word(input logic [7:0] b, input logic stopped,
                            output bit fires, output slc_pkg::slc_res_t res);
    logic        marked;
    logic [2:0]  plain_v;
    logic [13:0] want;
    marked  = (lead_char == slc_pkg::CH_STAR) || (lead_char == slc_pkg::CH_CARET);
    plain_v = (cmd_char == slc_pkg::CH_QUERY) ? slc_pkg::V_QUERY : slc_pkg::V_EXEC;
    want    = (pay_sum >> 1) + slc_pkg::CHK_OFFSET;
    fires   = 1'b0;
    res     = '{slc_pkg::V_EXEC,
                marked ? slc_pkg::START_MARKED : slc_pkg::START_PLAIN,
                held_len};
    if (held_len + 1 >= LineCap) begin
      // line is full: this word is dropped, held line reported
      res.verdict = slc_pkg::V_OVERFLOW;
      fires = 1'b1;
    end else if (b == slc_pkg::CH_NEWLINE) begin
      fires = (held_len != 0);
      if (stopped) begin
        res.verdict = slc_pkg::V_STOPPED;
      end else if (!marked) begin
        res.verdict = plain_v;
      end else if (copy_taken) begin
        if (lead_char == slc_pkg::CH_STAR) copy_taken = 1'b0;
        res.verdict = slc_pkg::V_SKIP;
      end else if (sent_chk < slc_pkg::CHK_OFFSET) begin
        res.verdict = slc_pkg::V_TXERR;
      end else if (want != {6'd0, sent_chk}) begin
        res.verdict = (lead_char == slc_pkg::CH_CARET) ? slc_pkg::V_SKIP : slc_pkg::V_TXERR;
      end else begin
        if (lead_char == slc_pkg::CH_CARET) copy_taken = 1'b1;
        res.verdict = plain_v;
      end
    end else if (b > slc_pkg::CH_SPACE) begin
      if (held_len == 0) begin
        lead_char = b;
        if (b != slc_pkg::CH_STAR && b != slc_pkg::CH_CARET) cmd_char = b;
      end else if (held_len == 1) begin
        if (marked) sent_chk = b;
      end else begin
        if (held_len == 2 && marked) cmd_char = b;
        pay_sum = pay_sum + b;
        if (pay_sum >= slc_pkg::SUM_WRAP) pay_sum = pay_sum - slc_pkg::SUM_WRAP;
      end
      held_len = held_len + 7'd1;
    end
    if (fires) clear_line();
  endtask

  // Offer one word after a random gap (none when no_idle is set) and hold it until accepted.
  task automatic send_word(input logic [7:0] b, input logic stopped, input bit typed,
                           input bit typed_fires, input slc_pkg::slc_res_t typed_res);
    int unsigned       gap;
    bit                fires;
    slc_pkg::slc_res_t res;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_rx_byte         <= b;
    in_machine_stopped <= stopped;
    do @(posedge clk); while (!in_ready);
    track_word(b, stopped, fires, res);
    if (typed) begin
      fires = typed_fires;
      res   = typed_res;
    end
    if (fires) pending_verdicts.push_back(res);
  endtask

  initial begin : result_side
    int unsigned       wait_left;
    int unsigned       seen;
    slc_pkg::slc_res_t want;
    wait_left = 0;
    seen      = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        seen++;
        if (pending_verdicts.size() == 0) begin
          report_mismatch("verdict with none pending", out_verdict, 0);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_verdict !== want.verdict)
            report_mismatch("verdict", out_verdict, want.verdict);
          if (out_payload_start !== want.payload_start)
            report_mismatch("payload_start", out_payload_start, want.payload_start);
          if (out_line_length !== want.line_length)
            report_mismatch("line_length", out_line_length, want.line_length);
        end
        // long hold-off lets the block back up into its input
        if (seen == 15 || seen == 50) wait_left = HoldCycles;
        else wait_left = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (wait_left != 0) begin
        out_ready <= 1'b0;
        wait_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned kept;
    int unsigned line_no;
    int unsigned n;
    int unsigned pick;
    int unsigned copies;
    int unsigned c;
    bit          stop_end;
    bit          star_tail;
    logic [7:0]  body[$];
    logic [7:0]  chk;
    logic [7:0]  noise;
    logic [13:0] acc;
    kept    = 0;
    line_no = 0;
    clear_line();
    copy_taken = 1'b0;
    dir_tab = '{
      '{8'h00, 1'b0, 1'b1, 1'b0, '0},
      '{8'h0A, 1'b0, 1'b1, 1'b0, '0},                               // empty line
      '{8'h3F, 1'b0, 1'b1, 1'b0, '0},
      '{8'h0A, 1'b0, 1'b1, 1'b1, '{slc_pkg::V_QUERY, slc_pkg::START_PLAIN, 7'd1}},
      '{8'hFF, 1'b0, 1'b1, 1'b0, '0},
      '{8'h0A, 1'b1, 1'b1, 1'b1, '{slc_pkg::V_STOPPED, slc_pkg::START_PLAIN, 7'd1}},
      '{8'h2A, 1'b0, 1'b1, 1'b0, '0},                               // lone marker
      '{8'h0A, 1'b0, 1'b1, 1'b1, '{slc_pkg::V_TXERR, slc_pkg::START_MARKED, 7'd1}},
      '{8'h5E, 1'b0, 1'b1, 1'b0, '0},                               // good copy, no payload
      '{8'h80, 1'b0, 1'b1, 1'b0, '0},
      '{8'h0A, 1'b0, 1'b1, 1'b1, '{slc_pkg::V_EXEC, slc_pkg::START_MARKED, 7'd2}},
      '{8'h2A, 1'b0, 1'b1, 1'b0, '0},                               // already taken
      '{8'h21, 1'b0, 1'b1, 1'b0, '0},
      '{8'h3F, 1'b0, 1'b1, 1'b0, '0},
      '{8'h0A, 1'b0, 1'b1, 1'b1, '{slc_pkg::V_SKIP, slc_pkg::START_MARKED, 7'd3}},
      '{8'h5E, 1'b0, 1'b0, 1'b0, '0},                               // bad copy
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'h41, 1'b0, 1'b0, 1'b0, '0},
      '{8'h0A, 1'b0, 1'b0, 1'b0, '0},
      '{8'h2A, 1'b0, 1'b1, 1'b0, '0},                               // checksum too low
      '{8'h7F, 1'b0, 1'b1, 1'b0, '0},
      '{8'h0A, 1'b0, 1'b1, 1'b1, '{slc_pkg::V_TXERR, slc_pkg::START_MARKED, 7'd2}},
      '{8'h2A, 1'b0, 1'b0, 1'b0, '0},                               // good marked query
      '{8'h9F, 1'b0, 1'b0, 1'b0, '0},
      '{8'h3F, 1'b0, 1'b0, 1'b0, '0},
      '{8'h0A, 1'b0, 1'b0, 1'b0, '0}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i])
      send_word(dir_tab[i].rx, dir_tab[i].stop, dir_tab[i].typed, dir_tab[i].fires,
                dir_tab[i].res);

    while (kept < RandWords) begin
      pick   = $urandom_range(0, 99);
      copies = 1;
      body.delete();
      if (line_no % 40 == 0) begin
        // long line around the capacity
        n = $urandom_range(LineCap - 3, LineCap + 5);
        repeat (n) body.push_back(8'($urandom_range(33, 255)));
      end else if (pick < 10) begin
        // garbage: any byte, newlines included
        n = $urandom_range(1, 12);
        repeat (n) body.push_back(8'($urandom_range(0, 255)));
      end else if (pick >= 15) begin
        n = $urandom_range(0, 10);
        repeat (n) body.push_back(8'($urandom_range(33, 126)));
        if (n != 0 && $urandom_range(0, 3) == 0) body[0] = slc_pkg::CH_QUERY;
        if (n != 0 && $urandom_range(0, 9) == 0)
          body[$urandom_range(0, n - 1)] = 8'($urandom_range(128, 255));
        if (pick >= 40) begin
          acc = '0;
          foreach (body[j]) begin
            acc = acc + body[j];
            if (acc >= slc_pkg::SUM_WRAP) acc = acc - slc_pkg::SUM_WRAP;
          end
          chk = 8'((acc >> 1) + slc_pkg::CHK_OFFSET);
          if ($urandom_range(0, 4) == 0) chk = 8'($urandom_range(0, 255));
          body.push_front(chk);
          body.push_front(slc_pkg::CH_STAR);
          // redundant caret copies, usually closed by a star copy
          if (pick >= 70) copies = $urandom_range(2, 4);
        end
      end
      star_tail = ($urandom_range(0, 3) != 0);
      stop_end  = ($urandom_range(0, 9) == 0);
      no_idle   = ($urandom_range(0, 4) == 0);
      for (c = 0; c < copies; c++) begin
        if (copies > 1)
          body[0] = (c == copies - 1 && star_tail) ? slc_pkg::CH_STAR : slc_pkg::CH_CARET;
        foreach (body[j]) begin
          if ($urandom_range(0, 9) == 0) begin
            noise = 8'($urandom_range(0, 32));
            if (noise == slc_pkg::CH_NEWLINE) noise = slc_pkg::CH_SPACE;
            send_word(noise, 1'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
            kept++;
          end
          send_word(body[j], 1'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
          kept++;
        end
        send_word(slc_pkg::CH_NEWLINE, stop_end, 1'b0, 1'b0, '0);
        kept++;
      end
      line_no++;
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
hdl/slc_pkg.sv
hdl/slc_line.sv
hdl/slc_out_reg.sv
hdl/serial_line_checksum_receiver.sv
tb/sv/tb_serial_line_checksum_receiver.sv
